// ----- hdl/des_pkg.sv -----
`default_nettype none
package des_pkg;

    localparam int unsigned BlockWidth = 64;
    localparam int unsigned HalfWidth = 32;
    localparam int unsigned KeyHalfWidth = 28;
    localparam int unsigned SubkeyWidth = 48;
    localparam int unsigned NumRounds = 16;

    typedef logic [7:0] t_tab64 [64];
    typedef logic [7:0] t_tab56 [56];
    typedef logic [7:0] t_tab48 [48];
    typedef logic [7:0] t_tab32 [32];
    typedef logic [3:0] t_sbox [8][64];

    localparam t_tab64 IP_TAB = '{
        8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
        8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
        8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
        8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9, 8'd1,
        8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
        8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
    };

    localparam t_tab64 FP_TAB = '{
        8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
        8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
        8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
        8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
        8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
        8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
        8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
        8'd33, 8'd1, 8'd41, 8'd9, 8'd49, 8'd17, 8'd57, 8'd25
    };

    localparam t_tab56 PC1_TAB = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
        8'd1, 8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
        8'd10, 8'd2, 8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
        8'd19, 8'd11, 8'd3, 8'd60, 8'd52, 8'd44, 8'd36,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
        8'd7, 8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
        8'd14, 8'd6, 8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
        8'd21, 8'd13, 8'd5, 8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam t_tab48 PC2_TAB = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1, 8'd5, 8'd3, 8'd28,
        8'd15, 8'd6, 8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,
        8'd26, 8'd8, 8'd16, 8'd7, 8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40,
        8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
        8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    localparam t_tab48 E_TAB = '{
        8'd32, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd4, 8'd5,
        8'd6, 8'd7, 8'd8, 8'd9, 8'd8, 8'd9, 8'd10, 8'd11,
        8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
        8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21,
        8'd22, 8'd23, 8'd24, 8'd25, 8'd24, 8'd25, 8'd26, 8'd27,
        8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1
    };

    localparam t_tab32 P_TAB = '{
        8'd16, 8'd7, 8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
        8'd1, 8'd15, 8'd23, 8'd26, 8'd5, 8'd18, 8'd31, 8'd10,
        8'd2, 8'd8, 8'd24, 8'd14, 8'd32, 8'd27, 8'd3, 8'd9,
        8'd19, 8'd13, 8'd30, 8'd6, 8'd22, 8'd11, 8'd4, 8'd25
    };

    // Rotation amount per round, bit r set means two places.
    localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100;

    // S-boxes indexed by row*16 + column.
    localparam t_sbox SBOX = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
    };

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] x, input logic two);
        return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    endfunction

    // Round function f(R,K) = P(S(E(R) xor K)).
    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0] seg;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(E_TAB[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            seg = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{seg[5], seg[0], seg[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(P_TAB[i])];
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/des_block_encrypt.sv -----
`default_nettype none
// DES encryption of 64-bit blocks, one Feistel round per pipeline stage. The key
// is held in a register written through i_cfg_we/i_cfg_data; its 16 round keys
// are derived from that register combinationally and registered, so a write
// reaches them through the key register and then the round-key registers. An
// item enters in every cycle in which the output side does not stall. The
// pipeline is the initial permutation stage, sixteen round stages and the
// final-permutation output register. A stall on the output freezes the whole
// pipeline, and i_stall passes straight to o_stall, so nothing is lost or repeated.
module des_block_encrypt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_plain_block,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_cipher_block
);

    localparam int unsigned NR = des_pkg::NumRounds;

    logic [63:0] r_key;
    logic [47:0] r_subkey [NR];
    logic [27:0] n_c [NR];
    logic [27:0] n_d [NR];
    logic [55:0] w_cd;

    logic        r_vld [NR+1];
    logic [31:0] r_l [NR+1];
    logic [31:0] r_r [NR+1];
    logic        r_out_vld;
    logic [63:0] r_out;
    logic        w_adv;

    assign w_adv   = !i_stall;
    assign o_stall = i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_data;
        end
    end

    // Round key schedule; rotations are fixed wiring per round.
    assign w_cd = des_pkg::perm_pc1(r_key);
    always_comb begin
        for (int i = 0; i < NR; i++) begin
            if (i == 0) begin
                n_c[i] = des_pkg::rot28(w_cd[55:28], des_pkg::ROT_TWO[0]);
                n_d[i] = des_pkg::rot28(w_cd[27:0], des_pkg::ROT_TWO[0]);
            end else begin
                n_c[i] = des_pkg::rot28(n_c[i-1], des_pkg::ROT_TWO[i]);
                n_d[i] = des_pkg::rot28(n_d[i-1], des_pkg::ROT_TWO[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NR; i++) r_subkey[i] <= des_pkg::perm_pc2({n_c[i], n_d[i]});
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NR; i++) r_vld[i] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i <= NR; i++) r_vld[i] <= r_vld[i-1];
            r_out_vld <= r_vld[NR];
        end
    end

    // Data path: stage 0 holds IP output, stage i+1 holds round i+1 output.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            {r_l[0], r_r[0]} <= des_pkg::perm_ip(i_plain_block);
            for (int i = 0; i < NR; i++) begin
                r_l[i+1] <= r_r[i];
                r_r[i+1] <= r_l[i] ^ des_pkg::feistel(r_r[i], r_subkey[i]);
            end
            r_out <= des_pkg::perm_fp({r_r[NR], r_l[NR]});
        end
    end

    assign o_valid        = r_out_vld;
    assign o_cipher_block = r_out;

endmodule
`default_nettype wire

// ----- tb/des_block_encrypt_test.sv -----
`default_nettype none
module des_block_encrypt_test;

    // The pipeline is 18 stages deep. After a key write the round keys pass through the round-key registers.
    localparam int unsigned PipeDepth = 18;
    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned RandomItems = 1600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [63:0] i_plain_block = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_cipher_block;

    // The key as the predictor sees it.
    logic [63:0] key_shadow = '0;
    logic [63:0] cipher_fifo[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    // While this is clear, neither side idles.
    bit          jitter_on = 1'b1;

    des_block_encrypt dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_plain_block(i_plain_block),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_cipher_block(o_cipher_block)
    );

    always #5 i_clk = ~i_clk;

    // Bit-serial DES predictor. Table entries number bits from the MSB, as in the standard.
    function automatic logic [63:0] des_encrypt(input logic [63:0] key, input logic [63:0] pt);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] b;
        logic [63:0] o;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        logic [31:0] s;
        logic [31:0] f;
        logic [47:0] k;
        logic [47:0] x;
        logic [55:0] cdr;
        logic [5:0] seg;
        int          sh;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(des_pkg::PC1_TAB[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 64; i++) b[63-i] = pt[64-int'(des_pkg::IP_TAB[i])];
        l = b[63:32];
        r = b[31:0];
        for (int rnd = 0; rnd < 16; rnd++) begin
            sh = (rnd == 0 || rnd == 1 || rnd == 8 || rnd == 15) ? 1 : 2;
            c = (c << sh) | (c >> (28 - sh));
            d = (d << sh) | (d >> (28 - sh));
            cdr = {c, d};
            for (int i = 0; i < 48; i++) k[47-i] = cdr[56-int'(des_pkg::PC2_TAB[i])];
            for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(des_pkg::E_TAB[i])];
            x = x ^ k;
            for (int i = 0; i < 8; i++) begin
                seg = x[47-6*i -: 6];
                // Row comes from the outer two bits, column from the middle four.
                s[31-4*i -: 4] = des_pkg::SBOX[i][{seg[5], seg[0]} * 16 + seg[4:1]];
            end
            for (int i = 0; i < 32; i++) f[31-i] = s[32-int'(des_pkg::P_TAB[i])];
            t = l ^ f;
            l = r;
            r = t;
        end
        b = {r, l};
        for (int i = 0; i < 64; i++) o[63-i] = b[64-int'(des_pkg::FP_TAB[i])];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
    endtask

    // Output side: random stall, and every accepted item is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (cipher_fifo.size() == 0) begin
                    report_mismatch("unexpected item", o_cipher_block, '0);
                end else begin
                    if (o_cipher_block !== cipher_fifo[0])
                        report_mismatch("cipher_block", o_cipher_block, cipher_fifo[0]);
                    void'(cipher_fifo.pop_front());
                end
            end
        end
        i_stall <= jitter_on && ($urandom_range(99) < 35);
    end

    // The watchdog counts cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one item, holding it until accepted. Expectation is queued at acceptance.
    // Valid stays high after acceptance; whoever waits next drops it first.
    task automatic send_block(input logic [63:0] pt, input bit has_golden,
                              input logic [63:0] golden);
        logic [63:0] want;
        while (jitter_on && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        want = des_encrypt(key_shadow, pt);
        if (has_golden && want !== golden)
            report_mismatch("predictor check", want, golden);
        i_valid <= 1'b1;
        i_plain_block <= pt;
        do @(posedge i_clk); while (o_stall);
        cipher_fifo = {cipher_fifo, want};
    endtask

    // Waits until every expected item has come, then lets the pipeline drain.
    task automatic drain_pipe;
        i_valid <= 1'b0;
        while (cipher_fifo.size() != 0) @(posedge i_clk);
        repeat (PipeDepth + 4) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [63:0] key);
        drain_pipe();
        i_cfg_we <= 1'b1;
        i_cfg_data <= key;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_shadow = key;
        // The round keys settle through the round-key registers after the write.
        repeat (3) @(posedge i_clk);
    endtask

    typedef struct {
        bit          wr_key;
        logic [63:0] value;
        bit          has_golden;
        logic [63:0] golden;
    } t_dir_row;

    // Directed table: key writes and blocks. Golden values are the well-known vectors.
    t_dir_row dir_table [18] = '{
        '{1'b0, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
        '{1'b1, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
        '{1'b0, 64'h0000000000000000, 1'b0, 64'h0},
        '{1'b1, 64'h133457799BBCDFF1, 1'b0, 64'h0},
        '{1'b0, 64'h0123456789ABCDEF, 1'b1, 64'h85E813540F0AB405},
        '{1'b0, 64'h8000000000000000, 1'b0, 64'h0},
        '{1'b0, 64'h0000000000000001, 1'b0, 64'h0},
        // Parity bits flipped: same result as the key above.
        '{1'b1, 64'h123556789ABDDEF0, 1'b0, 64'h0},
        '{1'b0, 64'h0123456789ABCDEF, 1'b1, 64'h85E813540F0AB405},
        // All parity bits only: equal to the all-zero key.
        '{1'b1, 64'h0101010101010101, 1'b0, 64'h0},
        '{1'b0, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
        // A weak key gets no special handling.
        '{1'b1, 64'hFEFEFEFEFEFEFEFE, 1'b0, 64'h0},
        '{1'b0, 64'h5555555555555555, 1'b0, 64'h0},
        '{1'b0, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
        '{1'b1, 64'h0E329232EA6D0D73, 1'b0, 64'h0},
        '{1'b0, 64'h8787878787878787, 1'b1, 64'h0000000000000000}
    };

    initial begin
        logic [63:0] pt;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[n]) begin
            if (dir_table[n].wr_key)
                write_key(dir_table[n].value);
            else
                send_block(dir_table[n].value, dir_table[n].has_golden, dir_table[n].golden);
        end

        // Random part in phases, each under a new random key; one phase runs without idling.
        for (int ph = 0; ph < 8; ph++) begin
            write_key({$urandom, $urandom});
            jitter_on = (ph != 3);
            for (int n = 0; n < RandomItems / 8; n++) begin
                pt = {$urandom, $urandom};
                case ($urandom_range(15))
                    0: pt = '0;
                    1: pt = '1;
                    2: pt = 64'h1 << $urandom_range(63);
                    default: ;
                endcase
                send_block(pt, 1'b0, '0);
                // The sender waits once per phase for the pipeline to empty.
                if (n == 40) begin
                    i_valid <= 1'b0;
                    while (cipher_fifo.size() != 0) @(posedge i_clk);
                end
            end
        end
        jitter_on = 1'b1;
        drain_pipe();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/des_pkg.sv
hdl/des_block_encrypt.sv
tb/des_block_encrypt_test.sv
